/* rtl/substring_replace_stream_assert.svh */
// assertion macros for the substring replace stream block
`ifndef SUBSTRING_REPLACE_STREAM_ASSERT_SVH
`define SUBSTRING_REPLACE_STREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srs check failed");
`define SRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srs check failed");
`else
`define SRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/srs_pkg.sv */
// shared constants, types and helpers of the substring replace stream block
package srs_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTE_W          = 8;
  localparam int REG_W           = 64;
  localparam int LEN_W           = 4;
  localparam int CFG_INDEX_W     = 8;
  localparam int REG_OCTETS      = REG_W / BYTE_W;
  localparam int OCT_IDX_W       = 5;
  localparam int FILL_W          = $clog2(MAX_PATTERN + 1);
  localparam int REP_W           = (MAX_REPLACEMENT > 0) ? $clog2(MAX_REPLACEMENT + 1) : 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_INDEX_W'(3);

  typedef struct packed {
    logic load;
    logic shift;
    logic cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } emit_t;

  typedef struct packed {
    logic valid;
    logic str_end;
  } finish_t;

  // octets past the register read as zero
  function automatic logic [BYTE_W-1:0] octet_of(input logic [REG_W-1:0] r,
                                                 input logic [OCT_IDX_W-1:0] i);
    logic [BYTE_W-1:0] o;
    o = '0;
    if (int'(i) < REG_OCTETS) begin
      o = r[i*BYTE_W +: BYTE_W];
    end
    return o;
  endfunction

endpackage

/* rtl/srs_in_if.sv */
// input byte channel of the substring replace stream block
interface srs_in_if;
  logic                      valid;
  logic                      ready;
  logic [srs_pkg::BYTE_W-1:0] text_byte;
  logic                      string_end;

  modport source(output valid, text_byte, string_end, input ready);
  modport sink(input valid, text_byte, string_end, output ready);
endinterface

/* rtl/srs_out_if.sv */
// result byte channel of the substring replace stream block
interface srs_out_if;
  logic                      valid;
  logic                      ready;
  logic [srs_pkg::BYTE_W-1:0] out_byte;
  logic                      run_last;
  logic                      output_end;

  modport source(output valid, out_byte, run_last, output_end, input ready);
  modport sink(input valid, out_byte, run_last, output_end, output ready);
endinterface

/* rtl/srs_cfg_if.sv */
// configuration write channel of the substring replace stream block
interface srs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srs_pkg::CFG_INDEX_W-1:0] index;
  logic [srs_pkg::REG_W-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/substring_replace_stream.sv */
// top level of the streaming substring find-and-replace block
//
// Bytes arrive on the text channel, one item per byte, string_end marking
// the last byte of a string. Every leftmost, non-overlapping occurrence of
// the pattern is rewritten as the replacement; other bytes pass unchanged.
// Each input item yields zero or more result items on the result channel;
// run_last flags the last result of an item, output_end that same result
// when the item ended its string. The cfg channel is always ready; the user
// must write the pattern and replacement registers between items, and the
// block itself does not enforce this. One item at a time: text is ready
// only while idle. A completed match sends the replacement; an end of string
// or a pattern change over a held partial match sends held bytes verbatim.
// The window is a row of cells that shifts one byte toward the front per
// window byte sent out.
// The result channel has an output register and a one-byte hold stage; a
// stalled receiver stalls the emitting step, nothing is dropped.
// Reset empties the window and loads pattern 0x00 of length one and an
// empty replacement; no clearing pass is needed.
`include "substring_replace_stream_assert.svh"
module substring_replace_stream (
  input  logic      clk,
  input  logic      rst,
  srs_in_if.sink    text,
  srs_out_if.source result,
  srs_cfg_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STALE  = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_REPL   = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]                       state, state_next;
  logic [srs_pkg::FILL_W-1:0]       fill, fill_next;
  logic                             stale, stale_next;
  logic [srs_pkg::REP_W-1:0]        rep_idx, rep_idx_next;
  logic [srs_pkg::BYTE_W-1:0]       pend_byte;
  logic                             pend_end;

  logic [srs_pkg::REG_W-1:0]        pattern_bytes;
  logic [srs_pkg::LEN_W-1:0]        pattern_length;
  logic [srs_pkg::REG_W-1:0]        replacement_bytes;
  logic [srs_pkg::LEN_W-1:0]        replacement_length;

  logic [srs_pkg::FILL_W-1:0]       plen;
  logic [srs_pkg::REP_W-1:0]        rlen;
  logic [srs_pkg::FILL_W-1:0]       cmp_len;
  logic [srs_pkg::BYTE_W-1:0]       rep_byte;
  logic [srs_pkg::BYTE_W-1:0]       load_data;
  logic                             load_win;
  logic                             shift_win;
  logic                             win_eq;

  logic [srs_pkg::BYTE_W-1:0]       win_q [srs_pkg::MAX_PATTERN];
  logic [srs_pkg::MAX_PATTERN-1:0]  hits;

  srs_pkg::emit_t                   emit;
  srs_pkg::finish_t                 finish;
  logic                             emit_ready;
  logic                             finish_ready;

  // effective lengths: zero pattern length counts as one, both saturate
  always_comb begin
    if (pattern_length == '0) begin
      plen = srs_pkg::FILL_W'(1);
    end else if (int'(pattern_length) > srs_pkg::MAX_PATTERN) begin
      plen = srs_pkg::FILL_W'(srs_pkg::MAX_PATTERN);
    end else begin
      plen = srs_pkg::FILL_W'(pattern_length);
    end
    if (int'(replacement_length) > srs_pkg::MAX_REPLACEMENT) begin
      rlen = srs_pkg::REP_W'(srs_pkg::MAX_REPLACEMENT);
    end else begin
      rlen = srs_pkg::REP_W'(replacement_length);
    end
  end

  assign cmp_len   = (fill < plen) ? fill : plen;
  assign rep_byte  = srs_pkg::octet_of(replacement_bytes, srs_pkg::OCT_IDX_W'(rep_idx));
  assign load_data = (state == ST_IDLE) ? text.text_byte : pend_byte;
  assign win_eq    = &hits;

  genvar gi;
  generate
    for (gi = 0; gi < srs_pkg::MAX_PATTERN; gi++) begin : g_cell
      srs_pkg::cell_ctrl_t        ctrl;
      logic [srs_pkg::BYTE_W-1:0] next_data;

      assign ctrl.load   = load_win && (fill == srs_pkg::FILL_W'(gi));
      assign ctrl.shift  = shift_win;
      assign ctrl.cmp_en = srs_pkg::FILL_W'(gi) < cmp_len;

      if (gi == srs_pkg::MAX_PATTERN - 1) begin : g_tail
        assign next_data = '0;
      end else begin : g_link
        assign next_data = win_q[gi+1];
      end

      srs_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_data (load_data),
        .next_data (next_data),
        .pat       (srs_pkg::octet_of(pattern_bytes, srs_pkg::OCT_IDX_W'(gi))),
        .q         (win_q[gi]),
        .hit       (hits[gi])
      );
    end
  endgenerate

  srs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .emit_ready   (emit_ready),
    .finish       (finish),
    .finish_ready (finish_ready),
    .result       (result)
  );

  assign text.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    stale_next     = stale;
    rep_idx_next   = rep_idx;
    emit.valid     = 1'b0;
    emit.data      = win_q[0];
    finish.valid   = 1'b0;
    finish.str_end = pend_end;
    load_win       = 1'b0;
    shift_win      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (text.valid) begin
          if (stale) begin
            state_next = ST_STALE;
          end else begin
            load_win   = 1'b1;
            fill_next  = fill + srs_pkg::FILL_W'(1);
            state_next = ST_CHECK;
          end
        end
      end
      ST_STALE: begin
        // bytes held under the old pattern go out verbatim
        if (fill == '0) begin
          stale_next = 1'b0;
          state_next = ST_APPEND;
        end else begin
          emit.valid = 1'b1;
          if (emit_ready) begin
            shift_win = 1'b1;
            fill_next = fill - srs_pkg::FILL_W'(1);
          end
        end
      end
      ST_APPEND: begin
        load_win   = 1'b1;
        fill_next  = fill + srs_pkg::FILL_W'(1);
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (fill == '0) begin
          state_next = ST_DONE;
        end else if (win_eq && (fill >= plen)) begin
          rep_idx_next = '0;
          state_next   = ST_REPL;
        end else if (win_eq) begin
          state_next = pend_end ? ST_FLUSH : ST_DONE;
        end else begin
          // not a prefix any more: oldest byte leaves, rest is checked again
          emit.valid = 1'b1;
          if (emit_ready) begin
            shift_win = 1'b1;
            fill_next = fill - srs_pkg::FILL_W'(1);
          end
        end
      end
      ST_REPL: begin
        if (rep_idx == rlen) begin
          fill_next  = '0;
          state_next = ST_DONE;
        end else begin
          emit.valid = 1'b1;
          emit.data  = rep_byte;
          if (emit_ready) begin
            rep_idx_next = rep_idx + srs_pkg::REP_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (fill == '0) begin
          state_next = ST_DONE;
        end else begin
          emit.valid = 1'b1;
          if (emit_ready) begin
            shift_win = 1'b1;
            fill_next = fill - srs_pkg::FILL_W'(1);
          end
        end
      end
      ST_DONE: begin
        finish.valid = 1'b1;
        if (finish_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cfg.valid && (fill != '0) &&
        ((cfg.index == srs_pkg::REG_PATTERN_BYTES) ||
         (cfg.index == srs_pkg::REG_PATTERN_LENGTH))) begin
      stale_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      fill               <= '0;
      stale              <= 1'b0;
      rep_idx            <= '0;
      pattern_bytes      <= '0;
      pattern_length     <= srs_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      stale   <= stale_next;
      rep_idx <= rep_idx_next;
      if (cfg.valid) begin
        case (cfg.index)
          srs_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg.data;
          srs_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg.data[srs_pkg::LEN_W-1:0];
          srs_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg.data;
          srs_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[srs_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && text.valid) begin
      pend_byte <= text.text_byte;
      pend_end  <= text.string_end;
    end
  end

  `SRS_ASSERT_IMP(a_idle_prefix, clk, rst, (state == ST_IDLE) && !stale, fill < plen)
  `SRS_ASSERT_IMP(a_stale_holds_bytes, clk, rst, (state == ST_IDLE) && stale, fill != '0)
  `SRS_ASSERT_IMP(a_repl_full_window, clk, rst, state == ST_REPL, fill == plen)
  `SRS_ASSERT_NXT(a_accept_leaves_idle, clk, rst, text.valid && text.ready, state != ST_IDLE)

endmodule

/* rtl/srs_cell.sv */
// one window cell: holds a byte, shifts toward the front, compares to its pattern byte
module srs_cell (
  input  logic                       clk,
  input  srs_pkg::cell_ctrl_t        ctrl,
  input  logic [srs_pkg::BYTE_W-1:0] load_data,
  input  logic [srs_pkg::BYTE_W-1:0] next_data,
  input  logic [srs_pkg::BYTE_W-1:0] pat,
  output logic [srs_pkg::BYTE_W-1:0] q,
  output logic                       hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= next_data;
    end
  end

  // cells past the compare length always agree
  assign hit = !ctrl.cmp_en || (q == pat);

endmodule

/* rtl/srs_out.sv */
// result stage: holds back one byte so the last of an item can be flagged
module srs_out (
  input  logic             clk,
  input  logic             rst,
  input  srs_pkg::emit_t   emit,
  output logic             emit_ready,
  input  srs_pkg::finish_t finish,
  output logic             finish_ready,
  srs_out_if.source        result
);

  logic                       held_valid;
  logic [srs_pkg::BYTE_W-1:0] held;
  logic                       out_valid;
  logic                       slot_free;
  logic                       push;
  logic                       emit_fire;
  logic                       finish_fire;

  assign slot_free    = !out_valid || result.ready;
  assign emit_ready   = !held_valid || slot_free;
  assign finish_ready = !held_valid || slot_free;
  assign emit_fire    = emit.valid && emit_ready;
  assign finish_fire  = finish.valid && finish_ready;
  assign push         = held_valid && slot_free && (emit.valid || finish.valid);
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_fire) begin
        held_valid <= 1'b1;
      end else if (finish_fire) begin
        held_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      held <= emit.data;
    end
    if (push) begin
      result.out_byte   <= held;
      result.run_last   <= finish.valid;
      result.output_end <= finish.valid && finish.str_end;
    end
  end

endmodule
